FILE: src/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Depth, widths, operation and status codes, item and cell control types.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_WIDTH = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_RM   = 2'd2;
  localparam logic [1:0] FUNC_READ = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] entry_time;
    logic [31:0] entry_tag;
    logic [3:0]  position;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_tag;
    logic [63:0] result_time;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic [31:0] head_tag;
    logic [63:0] head_time;
  } out_t;

  typedef struct packed {
    logic [63:0]          tm;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 ins;
    logic                 rm;
    logic [63:0]          tm;
    logic [TAG_WIDTH-1:0] tag;
  } cell_ctl_t;

  // handed from one cell to the next one up
  typedef struct packed {
    logic ins;
    logic found;
  } link_t;

endpackage

FILE: src/stq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted timer queue
// Holds one entry; shifts up on insert, down on removal, else holds.
// ----------------------------------------------------------------------------
module stq_cell (
  input  logic               clk_i,
  input  stq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  stq_pkg::link_t     left_link_i,
  input  stq_pkg::entry_t    left_entry_i,
  input  stq_pkg::entry_t    right_entry_i,
  output stq_pkg::link_t     link_o,
  output logic               first_o,
  output stq_pkg::entry_t    entry_o,
  output stq_pkg::entry_t    next_o
);
  import stq_pkg::*;

  entry_t entry_q, entry_d;
  logic   gt, match;

  assign gt    = occ_i && (entry_q.tm > ctl_i.tm);
  assign match = occ_i && (entry_q.tag == ctl_i.tag);

  assign link_o.ins   = !occ_i || gt;
  assign link_o.found = left_link_i.found || match;
  assign first_o      = match && !left_link_i.found;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (left_link_i.ins) begin
        entry_d = left_entry_i;
      end else if (link_o.ins) begin
        entry_d.tm  = ctl_i.tm;
        entry_d.tag = ctl_i.tag;
      end
    end else if (ctl_i.rm && link_o.found) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign next_o  = entry_d;

endmodule

FILE: src/sorted_timer_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_top: sorted timer priority queue
// Row of entry cells kept in deadline order, with a registered result.
// ----------------------------------------------------------------------------
// Each item is one operation (enqueue, dequeue, remove by tag, read at
// position) and is finished in the cycle it is accepted: every cell of the
// row compares its entry with the broadcast operands and shifts with its
// neighbors in that same edge. One item per clock is sustained; the result
// sits in an output register, and the input stalls only while that register
// is full and the output side stalls. Reset empties the queue at once.
module sorted_timer_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  stq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output stq_pkg::out_t out_data_o
);
  import stq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_t             out_q, out_d;

  cell_ctl_t        ctl;
  link_t            link   [DEPTH];
  link_t            left_l [DEPTH];
  logic             first  [DEPTH];
  logic             occ    [DEPTH];
  entry_t           entry  [DEPTH];
  entry_t           nxt    [DEPTH];
  entry_t           left_e [DEPTH];
  entry_t           right_e[DEPTH];

  logic             accept, full, enq_ok, deq_ok, rm_ok;
  entry_t           rm_sel;
  logic [TAG_WIDTH-1:0] in_tag;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign in_tag = in_data_i.entry_tag[TAG_WIDTH-1:0];

  assign enq_ok = accept && (in_data_i.func == FUNC_ENQ) && !full;
  assign deq_ok = accept && (in_data_i.func == FUNC_DEQ) && (count_q != '0);
  assign rm_ok  = accept && (in_data_i.func == FUNC_RM) && link[DEPTH-1].found;

  assign ctl.ins = enq_ok;
  assign ctl.rm  = deq_ok || rm_ok;
  assign ctl.tm  = in_data_i.entry_time;
  assign ctl.tag = in_tag;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign occ[k] = (CNT_W'(k) < count_q);
    if (k == 0) begin : g_head
      assign left_l[k].ins   = 1'b0;
      assign left_l[k].found = (in_data_i.func == FUNC_DEQ);
      assign left_e[k]       = entry[k];
    end else begin : g_body
      assign left_l[k] = link[k-1];
      assign left_e[k] = entry[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_e[k] = entry[k];
    end else begin : g_mid
      assign right_e[k] = entry[k+1];
    end
    stq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (occ[k]),
      .left_link_i   (left_l[k]),
      .left_entry_i  (left_e[k]),
      .right_entry_i (right_e[k]),
      .link_o        (link[k]),
      .first_o       (first[k]),
      .entry_o       (entry[k]),
      .next_o        (nxt[k])
    );
  end

  always_comb begin
    rm_sel = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (first[k]) begin
        rm_sel = rm_sel | entry[k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (deq_ok || rm_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_d             = '0;
    out_d.status      = ST_DONE;
    case (in_data_i.func)
      FUNC_ENQ: begin
        if (full) begin
          out_d.status = ST_FULL;
        end
      end
      FUNC_DEQ: begin
        if (deq_ok) begin
          out_d.result_tag  = 32'(entry[0].tag);
          out_d.result_time = entry[0].tm;
        end else begin
          out_d.status = ST_MISS;
        end
      end
      FUNC_RM: begin
        if (rm_ok) begin
          out_d.result_tag  = 32'(rm_sel.tag);
          out_d.result_time = rm_sel.tm;
        end else begin
          out_d.status = ST_MISS;
        end
      end
      FUNC_READ: begin
        if (CNT_W'(in_data_i.position) < count_q) begin
          out_d.result_time = entry[in_data_i.position[IDX_W-1:0]].tm;
        end else begin
          out_d.status = ST_MISS;
        end
      end
      default: begin
        out_d.status = ST_MISS;
      end
    endcase
    out_d.occupancy = 5'(count_d);
    out_d.is_empty  = (count_d == '0);
    if (count_d != '0) begin
      out_d.head_tag  = 32'(nxt[0].tag);
      out_d.head_time = nxt[0].tm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && (out_q.occupancy == 5'(count_q)))
    else $error("result missing or occupancy out of step");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.is_empty == (out_q.occupancy == 5'd0)))
    else $error("empty flag disagrees with occupancy");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count moved without an item");

endmodule
